// ===== hw/rtl/cnu_pkg.sv =====
// ============================================================================
// cnu_pkg: shared definitions for the collision normal unit
// Widths, pair kinds and sideband structures used across the pipeline.
// ============================================================================
package cnu_pkg;

    // Base formats.
    localparam int COORD_WIDTH      = 32;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int OUT_WIDTH        = NORMAL_FRAC_BITS + 2;
    localparam int HALF_WIDTH       = COORD_WIDTH - 1;

    // Difference vector and its magnitude.
    localparam int DIFF_WIDTH  = COORD_WIDTH + 2;
    localparam int MAG_WIDTH   = COORD_WIDTH + 1;
    localparam int SPLIT_LO    = (MAG_WIDTH + 1) / 2;
    localparam int SPLIT_HI    = MAG_WIDTH - SPLIT_LO;
    localparam int DSQ_WIDTH   = 2 * MAG_WIDTH + 2;
    localparam int SHIFT_WIDTH = $clog2(MAG_WIDTH + 1);

    // Normalized magnitudes, square root and division.
    localparam int NORM_WIDTH = 30;
    localparam int NSQ_WIDTH  = 2 * NORM_WIDTH + 2;
    localparam int ROOT_WIDTH = NORM_WIDTH + 1;
    localparam int ISQ_STAGES = NSQ_WIDTH / 2;
    localparam int NUM_WIDTH  = NORM_WIDTH + NORMAL_FRAC_BITS + 1;
    localparam int QUO_WIDTH  = NORMAL_FRAC_BITS + 2;

    // Pair kinds.
    typedef enum logic [1:0] {
        FUNC_SPH_SPH = 2'd0,
        FUNC_BOX_SPH = 2'd1,
        FUNC_SPH_BOX = 2'd2,
        FUNC_BOX_BOX = 2'd3
    } func_t;

    // Sideband that travels through the square root pipeline.
    typedef struct packed {
        logic [2:0][NORM_WIDTH-1:0] mn;
        logic [2:0]                 neg;
        logic                       no_contact;
        logic                       degenerate;
    } isq_side_t;

    // Sideband that travels through the divider pipeline.
    typedef struct packed {
        logic [2:0] neg;
        logic       no_contact;
        logic       degenerate;
    } div_side_t;

endpackage

// ===== hw/rtl/cnu_query_if.sv =====
// ============================================================================
// cnu_query_if: pair query channel
// Valid/ready channel carrying one pair query per transaction.
// ============================================================================
interface cnu_query_if;
    import cnu_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [1:0]                    func;
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] a_z;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] b_z;
    logic [HALF_WIDTH-1:0]         half_x;
    logic [HALF_WIDTH-1:0]         half_y;
    logic [HALF_WIDTH-1:0]         half_z;
    logic [HALF_WIDTH-1:0]         radius;

    modport source (
        output valid, func, a_x, a_y, a_z, b_x, b_y, b_z,
               half_x, half_y, half_z, radius,
        input  ready
    );

    modport sink (
        input  valid, func, a_x, a_y, a_z, b_x, b_y, b_z,
               half_x, half_y, half_z, radius,
        output ready
    );

endinterface

// ===== hw/rtl/cnu_result_if.sv =====
// ============================================================================
// cnu_result_if: collision normal result channel
// Valid/ready channel carrying one unit normal and flags per transaction.
// ============================================================================
interface cnu_result_if;
    import cnu_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] norm_x;
    logic signed [OUT_WIDTH-1:0] norm_y;
    logic signed [OUT_WIDTH-1:0] norm_z;
    logic                        no_contact;
    logic                        degenerate;

    modport source (
        output valid, norm_x, norm_y, norm_z, no_contact, degenerate,
        input  ready
    );

    modport sink (
        input  valid, norm_x, norm_y, norm_z, no_contact, degenerate,
        output ready
    );

endinterface

// ===== hw/rtl/cnu_isqrt.sv =====
// ============================================================================
// cnu_isqrt: pipelined integer square root
// One result bit per stage; the sideband and a valid bit move with the data.
// ============================================================================
module cnu_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [cnu_pkg::NSQ_WIDTH-1:0] in_sum,
    input  cnu_pkg::isq_side_t           in_side,
    output logic                         out_valid,
    output logic [cnu_pkg::ROOT_WIDTH-1:0] out_root,
    output cnu_pkg::isq_side_t           out_side
);
    import cnu_pkg::*;

    localparam int RW = NSQ_WIDTH + 1;

    logic [ISQ_STAGES-1:0] vld_reg;
    logic [ISQ_STAGES-1:0] vld_next;
    logic [NSQ_WIDTH-1:0]  rem_reg   [ISQ_STAGES];
    logic [NSQ_WIDTH-1:0]  rem_next  [ISQ_STAGES];
    logic [RW-1:0]         root_reg  [ISQ_STAGES];
    logic [RW-1:0]         root_next [ISQ_STAGES];
    isq_side_t             side_reg  [ISQ_STAGES];
    isq_side_t             side_next [ISQ_STAGES];

    // One trial subtraction per stage, from the highest power of four down.
    always_comb
    begin
        logic [NSQ_WIDTH-1:0] rem_prev;
        logic [RW-1:0]        root_prev;
        logic [RW-1:0]        bitv;
        logic [RW-1:0]        trial;
        for (int k = 0; k < ISQ_STAGES; k++)
        begin
            if (k == 0)
            begin
                rem_prev     = in_sum;
                root_prev    = '0;
                vld_next[k]  = in_valid;
                side_next[k] = in_side;
            end
            else
            begin
                rem_prev     = rem_reg[k-1];
                root_prev    = root_reg[k-1];
                vld_next[k]  = vld_reg[k-1];
                side_next[k] = side_reg[k-1];
            end
            bitv  = RW'(1) << (2 * (ISQ_STAGES - 1 - k));
            trial = root_prev + bitv;
            if ({1'b0, rem_prev} >= trial)
            begin
                rem_next[k]  = rem_prev - trial[NSQ_WIDTH-1:0];
                root_next[k] = (root_prev >> 1) + bitv;
            end
            else
            begin
                rem_next[k]  = rem_prev;
                root_next[k] = root_prev >> 1;
            end
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ISQ_STAGES; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid = vld_reg[ISQ_STAGES-1];
    assign out_root  = root_reg[ISQ_STAGES-1][ROOT_WIDTH-1:0];
    assign out_side  = side_reg[ISQ_STAGES-1];

endmodule

// ===== hw/rtl/cnu_divider.sv =====
// ============================================================================
// cnu_divider: pipelined three-lane restoring divider
// Divides three numerators by one shared root, one quotient bit per stage.
// ============================================================================
module cnu_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [2:0][cnu_pkg::NUM_WIDTH-1:0]  in_num,
    input  logic [cnu_pkg::ROOT_WIDTH-1:0]      in_den,
    input  cnu_pkg::div_side_t                  in_side,
    output logic                                out_valid,
    output logic [2:0][cnu_pkg::QUO_WIDTH-1:0]  out_quo,
    output cnu_pkg::div_side_t                  out_side
);
    import cnu_pkg::*;

    localparam int DW = ROOT_WIDTH + QUO_WIDTH;

    logic [QUO_WIDTH-1:0]              vld_reg;
    logic [QUO_WIDTH-1:0]              vld_next;
    logic [2:0][NUM_WIDTH-1:0]         rem_reg   [QUO_WIDTH];
    logic [2:0][NUM_WIDTH-1:0]         rem_next  [QUO_WIDTH];
    logic [2:0][QUO_WIDTH-1:0]         quo_reg   [QUO_WIDTH];
    logic [2:0][QUO_WIDTH-1:0]         quo_next  [QUO_WIDTH];
    logic [ROOT_WIDTH-1:0]             den_reg   [QUO_WIDTH];
    logic [ROOT_WIDTH-1:0]             den_next  [QUO_WIDTH];
    div_side_t                         side_reg  [QUO_WIDTH];
    div_side_t                         side_next [QUO_WIDTH];

    // Each stage settles one quotient bit, most significant first.
    always_comb
    begin
        logic [2:0][NUM_WIDTH-1:0] rem_prev;
        logic [2:0][QUO_WIDTH-1:0] quo_prev;
        logic [DW-1:0]             shifted;
        for (int k = 0; k < QUO_WIDTH; k++)
        begin
            if (k == 0)
            begin
                rem_prev     = in_num;
                quo_prev     = '0;
                den_next[k]  = in_den;
                vld_next[k]  = in_valid;
                side_next[k] = in_side;
            end
            else
            begin
                rem_prev     = rem_reg[k-1];
                quo_prev     = quo_reg[k-1];
                den_next[k]  = den_reg[k-1];
                vld_next[k]  = vld_reg[k-1];
                side_next[k] = side_reg[k-1];
            end
            shifted = DW'(den_next[k]) << (QUO_WIDTH - 1 - k);
            for (int i = 0; i < 3; i++)
            begin
                if (DW'(rem_prev[i]) >= shifted)
                begin
                    rem_next[k][i] = rem_prev[i] - shifted[NUM_WIDTH-1:0];
                    quo_next[k][i] = quo_prev[i] |
                                     (QUO_WIDTH'(1) << (QUO_WIDTH - 1 - k));
                end
                else
                begin
                    rem_next[k][i] = rem_prev[i];
                    quo_next[k][i] = quo_prev[i];
                end
            end
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QUO_WIDTH; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                quo_reg[k]  <= quo_next[k];
                den_reg[k]  <= den_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid = vld_reg[QUO_WIDTH-1];
    assign out_quo   = quo_reg[QUO_WIDTH-1];
    assign out_side  = side_reg[QUO_WIDTH-1];

endmodule

// ===== hw/rtl/collision_normal_unit.sv =====
// ============================================================================
// collision_normal_unit: unit collision normal for one pair query
// Deep pipeline from pair query to Q2.14 unit normal with contact flags.
// ============================================================================
//  Channel   Role   Payload
//  query     sink   func, a_x..b_z, half_x..half_z, radius
//  result    source norm_x, norm_y, norm_z, no_contact, degenerate
//
//  One query enters per cycle while the result is not stalled. There are 57
//  register stages from the query port to the result register.
//  Most of the depth lies in the 31-stage square root and the 16-stage divider.
//  Reset clears only the valid bits; no other state is kept between queries.
//  A stalled result holds the whole pipeline in place, nothing is dropped.
// ============================================================================
module collision_normal_unit (
    input logic         clk,
    input logic         rst_n,
    cnu_query_if.sink   query,
    cnu_result_if.source result
);
    import cnu_pkg::*;

    logic en;

    // Stage 1: center difference.
    logic                          s1_vld_reg;
    func_t                         s1_func_reg;
    logic signed [DIFF_WIDTH-1:0]  s1_e_reg [3];
    logic [HALF_WIDTH-1:0]         s1_h_reg [3];
    logic [HALF_WIDTH-1:0]         s1_r_reg;

    // Stage 2: clamp distance and box overlap.
    logic                          s2_vld_reg;
    func_t                         s2_func_reg;
    logic signed [DIFF_WIDTH-1:0]  s2_d_reg  [3];
    logic signed [DIFF_WIDTH-1:0]  s2_ov_reg [3];
    logic [HALF_WIDTH-1:0]         s2_r_reg;

    // Stage 3: axis pick and magnitudes.
    logic                          s3_vld_reg;
    func_t                         s3_func_reg;
    logic [MAG_WIDTH-1:0]          s3_m_reg [3];
    logic [2:0]                    s3_neg_reg;
    logic [HALF_WIDTH-1:0]         s3_r_reg;

    // Stage 4: partial products and largest magnitude.
    logic                          s4_vld_reg;
    func_t                         s4_func_reg;
    logic [MAG_WIDTH-1:0]          s4_m_reg [3];
    logic [2:0]                    s4_neg_reg;
    logic [2*SPLIT_HI-1:0]         s4_hh_reg [4];
    logic [SPLIT_HI+SPLIT_LO-1:0]  s4_hl_reg [4];
    logic [2*SPLIT_LO-1:0]         s4_ll_reg [4];
    logic [MAG_WIDTH-1:0]          s4_top_reg;

    // Stage 5: squares and leading bit position.
    logic                          s5_vld_reg;
    func_t                         s5_func_reg;
    logic [MAG_WIDTH-1:0]          s5_m_reg [3];
    logic [2:0]                    s5_neg_reg;
    logic [DSQ_WIDTH-1:0]          s5_sq_reg [4];
    logic [SHIFT_WIDTH-1:0]        s5_bits_reg;
    logic                          s5_zero_reg;

    // Stage 6: contact decision and normalizing shift.
    logic                          s6_vld_reg;
    isq_side_t                     s6_side_reg;

    // Stage 7: squares of normalized magnitudes.
    logic                          s7_vld_reg;
    logic [2*NORM_WIDTH-1:0]       s7_msq_reg [3];
    isq_side_t                     s7_side_reg;

    // Stage 8: sum of squares.
    logic                          s8_vld_reg;
    logic [NSQ_WIDTH-1:0]          s8_sum_reg;
    isq_side_t                     s8_side_reg;

    // Square root outputs.
    logic                          isq_vld;
    logic [ROOT_WIDTH-1:0]         isq_root;
    isq_side_t                     isq_side;

    // Stage 9: rounded numerators.
    logic                          s9_vld_reg;
    logic [2:0][NUM_WIDTH-1:0]     s9_num_reg;
    logic [ROOT_WIDTH-1:0]         s9_den_reg;
    div_side_t                     s9_side_reg;

    // Divider outputs.
    logic                          div_vld;
    logic [2:0][QUO_WIDTH-1:0]     div_quo;
    div_side_t                     div_side;

    // Output register.
    logic                          out_vld_reg;
    logic signed [OUT_WIDTH-1:0]   out_norm_reg [3];
    logic                          out_nc_reg;
    logic                          out_dg_reg;

    // Next values.
    func_t                         s1_func_next;
    logic signed [DIFF_WIDTH-1:0]  s1_e_next [3];
    logic signed [DIFF_WIDTH-1:0]  s2_d_next  [3];
    logic signed [DIFF_WIDTH-1:0]  s2_ov_next [3];
    logic [MAG_WIDTH-1:0]          s3_m_next [3];
    logic [2:0]                    s3_neg_next;
    logic [2*SPLIT_HI-1:0]         s4_hh_next [4];
    logic [SPLIT_HI+SPLIT_LO-1:0]  s4_hl_next [4];
    logic [2*SPLIT_LO-1:0]         s4_ll_next [4];
    logic [MAG_WIDTH-1:0]          s4_top_next;
    logic [DSQ_WIDTH-1:0]          s5_sq_next [4];
    logic [SHIFT_WIDTH-1:0]        s5_bits_next;
    isq_side_t                     s6_side_next;
    logic [2:0][NUM_WIDTH-1:0]     s9_num_next;
    logic [ROOT_WIDTH-1:0]         s9_den_next;
    logic signed [OUT_WIDTH-1:0]   out_norm_next [3];

    // The whole pipeline advances unless a finished result is held.
    assign en          = !out_vld_reg || result.ready;
    assign query.ready = en;

    // Stage 1: center difference; for pairs with a sphere, the sphere center minus the other.
    always_comb
    begin
        logic signed [COORD_WIDTH-1:0] a_in [3];
        logic signed [COORD_WIDTH-1:0] b_in [3];
        a_in[0] = query.a_x;
        a_in[1] = query.a_y;
        a_in[2] = query.a_z;
        b_in[0] = query.b_x;
        b_in[1] = query.b_y;
        b_in[2] = query.b_z;
        s1_func_next = func_t'(query.func);
        for (int i = 0; i < 3; i++)
        begin
            if (s1_func_next == FUNC_BOX_SPH || s1_func_next == FUNC_BOX_BOX)
                s1_e_next[i] = DIFF_WIDTH'(b_in[i]) - DIFF_WIDTH'(a_in[i]);
            else
                s1_e_next[i] = DIFF_WIDTH'(a_in[i]) - DIFF_WIDTH'(b_in[i]);
        end
    end

    // Stage 2: distance outside the box for box-sphere pairs, and overlap for box pairs.
    always_comb
    begin
        logic signed [DIFF_WIDTH-1:0] hs;
        logic signed [DIFF_WIDTH-1:0] t_lo;
        logic signed [DIFF_WIDTH-1:0] t_hi;
        logic signed [DIFF_WIDTH-1:0] mag_e;
        for (int i = 0; i < 3; i++)
        begin
            hs    = signed'(DIFF_WIDTH'(s1_h_reg[i]));
            t_lo  = s1_e_reg[i] + hs;
            t_hi  = s1_e_reg[i] - hs;
            mag_e = (s1_e_reg[i] < 0) ? -s1_e_reg[i] : s1_e_reg[i];
            s2_ov_next[i] = hs - mag_e;
            if (s1_func_reg == FUNC_BOX_SPH || s1_func_reg == FUNC_SPH_BOX)
            begin
                if (t_lo < 0)
                    s2_d_next[i] = t_lo;
                else if (t_hi > 0)
                    s2_d_next[i] = t_hi;
                else
                    s2_d_next[i] = '0;
            end
            else
            begin
                s2_d_next[i] = s1_e_reg[i];
            end
        end
    end

    // Stage 3: keep only the least-overlap axis for box pairs; take magnitudes.
    always_comb
    begin
        logic                         ax0;
        logic                         ax1;
        logic [2:0]                   keep;
        logic signed [DIFF_WIDTH-1:0] dz;
        logic signed [DIFF_WIDTH-1:0] dm;
        ax0 = (s2_ov_reg[0] < s2_ov_reg[1]) && (s2_ov_reg[0] < s2_ov_reg[2]);
        ax1 = !ax0 && (s2_ov_reg[1] < s2_ov_reg[0]) && (s2_ov_reg[1] < s2_ov_reg[2]);
        if (s2_func_reg == FUNC_BOX_BOX)
            keep = {!ax0 && !ax1, ax1, ax0};
        else
            keep = 3'b111;
        for (int i = 0; i < 3; i++)
        begin
            dz = keep[i] ? s2_d_reg[i] : '0;
            dm = (dz < 0) ? -dz : dz;
            s3_neg_next[i] = dz < 0;
            s3_m_next[i]   = dm[MAG_WIDTH-1:0];
        end
    end

    // Stage 4: split products for exact squares; largest magnitude.
    always_comb
    begin
        logic [MAG_WIDTH-1:0] v;
        for (int j = 0; j < 4; j++)
        begin
            v = (j < 3) ? s3_m_reg[j] : MAG_WIDTH'(s3_r_reg);
            s4_hh_next[j] = (2*SPLIT_HI)'(v[MAG_WIDTH-1:SPLIT_LO]) *
                            (2*SPLIT_HI)'(v[MAG_WIDTH-1:SPLIT_LO]);
            s4_hl_next[j] = (SPLIT_HI+SPLIT_LO)'(v[MAG_WIDTH-1:SPLIT_LO]) *
                            (SPLIT_HI+SPLIT_LO)'(v[SPLIT_LO-1:0]);
            s4_ll_next[j] = (2*SPLIT_LO)'(v[SPLIT_LO-1:0]) *
                            (2*SPLIT_LO)'(v[SPLIT_LO-1:0]);
        end
        s4_top_next = s3_m_reg[0];
        if (s3_m_reg[1] > s4_top_next)
            s4_top_next = s3_m_reg[1];
        if (s3_m_reg[2] > s4_top_next)
            s4_top_next = s3_m_reg[2];
    end

    // Stage 5: assemble squares; count significant bits of the largest.
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            s5_sq_next[j] = (DSQ_WIDTH'(s4_hh_reg[j]) << (2 * SPLIT_LO)) +
                            (DSQ_WIDTH'(s4_hl_reg[j]) << (SPLIT_LO + 1)) +
                            DSQ_WIDTH'(s4_ll_reg[j]);
        end
        s5_bits_next = '0;
        for (int b = 0; b < MAG_WIDTH; b++)
        begin
            if (s4_top_reg[b])
                s5_bits_next = SHIFT_WIDTH'(b + 1);
        end
    end

    // Stage 6: exact contact test and shift to the normalized range.
    always_comb
    begin
        logic [DSQ_WIDTH-1:0]            dsq;
        logic                            box;
        logic [MAG_WIDTH+NORM_WIDTH-1:0] wide;
        dsq = s5_sq_reg[0] + s5_sq_reg[1] + s5_sq_reg[2];
        box = (s5_func_reg == FUNC_BOX_SPH) || (s5_func_reg == FUNC_SPH_BOX);
        s6_side_next.no_contact = box && !(dsq < s5_sq_reg[3]);
        s6_side_next.degenerate = !s6_side_next.no_contact && s5_zero_reg;
        s6_side_next.neg = s5_neg_reg ^ {3{s5_func_reg == FUNC_SPH_BOX}};
        for (int i = 0; i < 3; i++)
        begin
            wide = {s5_m_reg[i], NORM_WIDTH'(0)} >> s5_bits_reg;
            s6_side_next.mn[i] = wide[NORM_WIDTH-1:0];
        end
    end

    // Stage 9: rounded numerators and a divisor kept away from zero.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s9_num_next[i] = (NUM_WIDTH'(isq_side.mn[i]) << NORMAL_FRAC_BITS) +
                             NUM_WIDTH'(isq_root >> 1);
        end
        s9_den_next = (isq_root == '0) ? ROOT_WIDTH'(1) : isq_root;
    end

    // Output: apply the sign and clear the normal when a flag is set.
    always_comb
    begin
        logic signed [OUT_WIDTH-1:0] v;
        for (int i = 0; i < 3; i++)
        begin
            v = signed'(OUT_WIDTH'(div_quo[i]));
            if (div_side.no_contact || div_side.degenerate)
                out_norm_next[i] = '0;
            else if (div_side.neg[i])
                out_norm_next[i] = -v;
            else
                out_norm_next[i] = v;
        end
    end

    // Valid bits of the front and back stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= query.valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= isq_vld;
            out_vld_reg <= div_vld;
        end
    end

    // Payload registers of the front and back stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_func_reg <= s1_func_next;
            s1_e_reg    <= s1_e_next;
            s1_h_reg[0] <= query.half_x;
            s1_h_reg[1] <= query.half_y;
            s1_h_reg[2] <= query.half_z;
            s1_r_reg    <= query.radius;

            s2_func_reg <= s1_func_reg;
            s2_d_reg    <= s2_d_next;
            s2_ov_reg   <= s2_ov_next;
            s2_r_reg    <= s1_r_reg;

            s3_func_reg <= s2_func_reg;
            s3_m_reg    <= s3_m_next;
            s3_neg_reg  <= s3_neg_next;
            s3_r_reg    <= s2_r_reg;

            s4_func_reg <= s3_func_reg;
            s4_m_reg    <= s3_m_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_hh_reg   <= s4_hh_next;
            s4_hl_reg   <= s4_hl_next;
            s4_ll_reg   <= s4_ll_next;
            s4_top_reg  <= s4_top_next;

            s5_func_reg <= s4_func_reg;
            s5_m_reg    <= s4_m_reg;
            s5_neg_reg  <= s4_neg_reg;
            s5_sq_reg   <= s5_sq_next;
            s5_bits_reg <= s5_bits_next;
            s5_zero_reg <= (s4_top_reg == '0);

            s6_side_reg <= s6_side_next;

            for (int i = 0; i < 3; i++)
            begin
                s7_msq_reg[i] <= (2*NORM_WIDTH)'(s6_side_reg.mn[i]) *
                                 (2*NORM_WIDTH)'(s6_side_reg.mn[i]);
            end
            s7_side_reg <= s6_side_reg;

            s8_sum_reg  <= NSQ_WIDTH'(s7_msq_reg[0]) + NSQ_WIDTH'(s7_msq_reg[1]) +
                           NSQ_WIDTH'(s7_msq_reg[2]);
            s8_side_reg <= s7_side_reg;

            s9_num_reg             <= s9_num_next;
            s9_den_reg             <= s9_den_next;
            s9_side_reg.neg        <= isq_side.neg;
            s9_side_reg.no_contact <= isq_side.no_contact;
            s9_side_reg.degenerate <= isq_side.degenerate;

            out_norm_reg <= out_norm_next;
            out_nc_reg   <= div_side.no_contact;
            out_dg_reg   <= div_side.degenerate;
        end
    end

    // Square root of the sum of squares.
    cnu_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s8_vld_reg),
        .in_sum    (s8_sum_reg),
        .in_side   (s8_side_reg),
        .out_valid (isq_vld),
        .out_root  (isq_root),
        .out_side  (isq_side)
    );

    // Rounded division of each component by the length.
    cnu_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s9_vld_reg),
        .in_num    (s9_num_reg),
        .in_den    (s9_den_reg),
        .in_side   (s9_side_reg),
        .out_valid (div_vld),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    // Result channel.
    assign result.valid      = out_vld_reg;
    assign result.norm_x     = out_norm_reg[0];
    assign result.norm_y     = out_norm_reg[1];
    assign result.norm_z     = out_norm_reg[2];
    assign result.no_contact = out_nc_reg;
    assign result.degenerate = out_dg_reg;

endmodule

// ===== hw/rtl/cnu_checker.sv =====
// ============================================================================
// cnu_checker: port-level checks for the collision normal unit
// Watches the query and result channels and flags illegal behavior.
// ============================================================================
module cnu_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               query_ready,
    input logic                               result_valid,
    input logic                               result_ready,
    input logic signed [cnu_pkg::OUT_WIDTH-1:0] norm_x,
    input logic signed [cnu_pkg::OUT_WIDTH-1:0] norm_y,
    input logic signed [cnu_pkg::OUT_WIDTH-1:0] norm_z,
    input logic                               no_contact,
    input logic                               degenerate
);
    import cnu_pkg::*;

    // A held result stays offered.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped while stalled");

    // A held result keeps its payload.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(norm_x) && $stable(norm_y) &&
        $stable(norm_z) && $stable(no_contact) && $stable(degenerate))
        else $error("result payload changed while stalled");

    // The two flags never come together.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(no_contact && degenerate))
        else $error("no_contact and degenerate both set");

    // A flagged result carries a zero normal.
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (no_contact || degenerate) |->
        norm_x == '0 && norm_y == '0 && norm_z == '0)
        else $error("flagged result with nonzero normal");

    // With no result waiting, queries are always taken.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> query_ready)
        else $error("query not ready with empty output");

endmodule

bind collision_normal_unit cnu_checker u_cnu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .query_ready  (query.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .norm_x       (result.norm_x),
    .norm_y       (result.norm_y),
    .norm_z       (result.norm_z),
    .no_contact   (result.no_contact),
    .degenerate   (result.degenerate)
);
